// File: rtl/sound_sequence_stream_validator_core_defines.svh
// Assertion macros used by rtl/sound_sequence_stream_validator_core.sv.
`ifndef SOUND_SEQUENCE_STREAM_VALIDATOR_CORE_DEFINES_SVH
`define SOUND_SEQUENCE_STREAM_VALIDATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SSSV_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SSSV_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sssv_pkg.sv
package sssv_pkg;

  localparam int unsigned MaxStreamBytes = 65536;
  localparam int unsigned CntW           = $clog2(MaxStreamBytes + 1);
  localparam int unsigned LenW           = 17;

  localparam logic [7:0] StEnd     = 8'hFF;
  localparam logic [7:0] EndMeta   = 8'h2F;
  localparam logic [7:0] EndZero   = 8'h00;
  localparam logic [7:0] StPayload = 8'hA0;
  localparam logic [7:0] StCommand = 8'hB0;
  localparam logic [2:0] MaxDelay  = 3'd5;

  localparam logic [7:0] CmdOne   = 8'h01;
  localparam logic [7:0] CmdTwo   = 8'h02;
  localparam logic [7:0] CmdSeven = 8'h07;
  localparam logic [7:0] CmdTen   = 8'h0A;
  localparam logic [7:0] CmdHi41  = 8'h41;
  localparam logic [7:0] CmdHi60  = 8'h60;

  typedef enum logic [2:0] {
    PH_EVENT,
    PH_END_2F,
    PH_END_00,
    PH_PAYLOAD,
    PH_CMD,
    PH_DELAY
  } phase_e;

  typedef enum logic [1:0] {
    RS_NONE,
    RS_A0,
    RS_B0
  } run_status_e;

  typedef enum logic [1:0] {
    RC_CONT,
    RC_BAD,
    RC_END
  } parse_code_e;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic            verdict;
    logic [LenW-1:0] stream_length;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } parse_res_t;

  // Payload bytes after a B0 command byte; zero marks an unknown command.
  function automatic logic [2:0] cmd_len(logic [7:0] c);
    logic [2:0] len;
    len = 3'd0;
    if (c == CmdOne || c == CmdTwo || c == CmdHi60) begin
      len = 3'd3;
    end else if (c == CmdSeven || c == CmdTen || c == CmdHi41) begin
      len = 3'd4;
    end
    return len;
  endfunction

endpackage

// File: rtl/sound_sequence_stream_validator_core.sv
// Sound-sequence stream validator.
// Input channel (in_valid_i / in_ready_o / in_data_i): one bytecode byte per
// transfer, with last_byte marking the final byte of the buffer.
// Output channel (out_valid_o / out_ready_i / out_data_o): at most one verdict
// per stream: verdict 0 with the byte length on the FF 2F 00 end marker,
// verdict 1 with length 0 on a grammar error, truncation or buffer limit.
// Bytes after a verdict yield nothing; the parser restarts after last_byte.
// Throughput is one byte per cycle while in_ready_o is high: the parse state
// is registered, computed from the state registers and the incoming byte.
// Each verdict reaches out_valid_o through the output register or the skid register.
// A two-entry output stage (output register plus skid register) holds results
// while the receiver stalls; in_ready_o drops only when both entries are
// full, i.e. two verdicts are waiting.
// Reset clears the parse state and both output entries; in_ready_o is high
// right after reset.
`include "sound_sequence_stream_validator_core_defines.svh"

module sound_sequence_stream_validator_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sssv_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sssv_pkg::out_item_t  out_data_o
);

  sssv_pkg::parse_res_t res;
  logic                 accept;
  logic                 out_free;
  logic                 out_valid_q, out_valid_d;
  logic                 skid_valid_q, skid_valid_d;
  sssv_pkg::out_item_t  out_q, out_d;
  sssv_pkg::out_item_t  skid_q, skid_d;

  assign in_ready_o = !skid_valid_q;
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  sssv_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_data_i),
    .res_o    (res)
  );

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        // advance the held result, park a new one behind it
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = res.valid;
        skid_d       = res.item;
      end else begin
        out_valid_d = res.valid;
        out_d       = res.item;
      end
    end else if (res.valid) begin
      skid_valid_d = 1'b1;
      skid_d       = res.item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SSSV_ASSERT_IMP(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full while output empty")
  `SSSV_ASSERT_IMP(a_bad_zero_len, out_valid_o && out_data_o.verdict, out_data_o.stream_length == '0, "malformed verdict with nonzero length")
  `SSSV_ASSERT_NXT(a_stall_parks, res.valid && out_valid_q && !out_ready_i, skid_valid_q, "result lost while output stalled")
  `SSSV_ASSERT_NXT(a_out_held, out_valid_q && !out_ready_i, out_valid_q && $stable(out_q), "stalled result changed")

endmodule

// File: rtl/sssv_parse.sv
module sssv_parse (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  sssv_pkg::in_item_t   item_i,
  output sssv_pkg::parse_res_t res_o
);

  sssv_pkg::phase_e            phase_q, phase_d;
  sssv_pkg::run_status_e       run_q, run_d;
  logic [2:0]                  left_q, left_d;
  logic [2:0]                  dseen_q, dseen_d;
  logic [sssv_pkg::CntW-1:0]   count_q, count_d;
  logic                        given_q, given_d;

  sssv_pkg::phase_e            ph_nx;
  sssv_pkg::run_status_e       run_nx;
  logic [2:0]                  left_nx;
  logic [2:0]                  dseen_nx;
  sssv_pkg::parse_code_e       code;
  sssv_pkg::parse_code_e       code_fin;
  logic [sssv_pkg::CntW-1:0]   count_inc;
  logic [7:0]                  b;
  logic [2:0]                  clen;
  logic [2:0]                  dseen_inc;

  assign b         = item_i.stream_byte;
  assign clen      = sssv_pkg::cmd_len(b);
  assign dseen_inc = dseen_q + 3'd1;
  assign count_inc = count_q + sssv_pkg::CntW'(1);

  // Grammar next state
  always_comb begin
    ph_nx    = phase_q;
    run_nx   = run_q;
    left_nx  = left_q;
    dseen_nx = dseen_q;
    unique case (phase_q)
      sssv_pkg::PH_EVENT: begin
        if (b[7]) begin
          if (b == sssv_pkg::StEnd) begin
            ph_nx = sssv_pkg::PH_END_2F;
          end else if (b == sssv_pkg::StPayload) begin
            run_nx  = sssv_pkg::RS_A0;
            left_nx = 3'd3;
            ph_nx   = sssv_pkg::PH_PAYLOAD;
          end else if (b == sssv_pkg::StCommand) begin
            run_nx = sssv_pkg::RS_B0;
            ph_nx  = sssv_pkg::PH_CMD;
          end else begin
            run_nx = sssv_pkg::RS_NONE;
          end
        end else if (run_q == sssv_pkg::RS_A0) begin
          // status byte omitted: this byte is the first payload byte
          left_nx = 3'd2;
          ph_nx   = sssv_pkg::PH_PAYLOAD;
        end else if (run_q == sssv_pkg::RS_B0 && clen != 3'd0) begin
          left_nx = clen;
          ph_nx   = sssv_pkg::PH_PAYLOAD;
        end
      end
      sssv_pkg::PH_END_2F: begin
        if (b == sssv_pkg::EndMeta) ph_nx = sssv_pkg::PH_END_00;
      end
      sssv_pkg::PH_END_00: begin
        ph_nx = phase_q;
      end
      sssv_pkg::PH_CMD: begin
        if (clen != 3'd0) begin
          left_nx = clen;
          ph_nx   = sssv_pkg::PH_PAYLOAD;
        end
      end
      sssv_pkg::PH_PAYLOAD: begin
        if (left_q > 3'd1) begin
          left_nx = left_q - 3'd1;
        end else begin
          left_nx  = 3'd0;
          dseen_nx = 3'd0;
          ph_nx    = sssv_pkg::PH_DELAY;
        end
      end
      sssv_pkg::PH_DELAY: begin
        dseen_nx = dseen_inc;
        if (!b[7]) begin
          dseen_nx = 3'd0;
          ph_nx    = sssv_pkg::PH_EVENT;
        end
      end
      default: begin
        ph_nx = phase_q;
      end
    endcase
  end

  // Grammar outcome of this byte
  always_comb begin
    code = sssv_pkg::RC_BAD;
    unique case (phase_q)
      sssv_pkg::PH_EVENT: begin
        if (b[7]) begin
          if (b == sssv_pkg::StEnd || b == sssv_pkg::StPayload ||
              b == sssv_pkg::StCommand) begin
            code = sssv_pkg::RC_CONT;
          end
        end else if (run_q == sssv_pkg::RS_A0) begin
          code = sssv_pkg::RC_CONT;
        end else if (run_q == sssv_pkg::RS_B0 && clen != 3'd0) begin
          code = sssv_pkg::RC_CONT;
        end
      end
      sssv_pkg::PH_END_2F: begin
        if (b == sssv_pkg::EndMeta) code = sssv_pkg::RC_CONT;
      end
      sssv_pkg::PH_END_00: begin
        if (b == sssv_pkg::EndZero) code = sssv_pkg::RC_END;
      end
      sssv_pkg::PH_CMD: begin
        if (clen != 3'd0) code = sssv_pkg::RC_CONT;
      end
      sssv_pkg::PH_PAYLOAD: begin
        code = sssv_pkg::RC_CONT;
      end
      sssv_pkg::PH_DELAY: begin
        if (!b[7] || dseen_inc < sssv_pkg::MaxDelay) code = sssv_pkg::RC_CONT;
      end
      default: begin
        code = sssv_pkg::RC_BAD;
      end
    endcase
    // truncation or buffer limit turns a pending parse into a failure
    code_fin = code;
    if (code == sssv_pkg::RC_CONT &&
        (item_i.last_byte || count_inc == sssv_pkg::CntW'(sssv_pkg::MaxStreamBytes))) begin
      code_fin = sssv_pkg::RC_BAD;
    end
  end

  always_comb begin
    phase_d = phase_q;
    run_d   = run_q;
    left_d  = left_q;
    dseen_d = dseen_q;
    count_d = count_q;
    given_d = given_q;
    res_o   = '0;
    if (accept_i) begin
      if (!given_q) begin
        phase_d = ph_nx;
        run_d   = run_nx;
        left_d  = left_nx;
        dseen_d = dseen_nx;
        count_d = count_inc;
        if (code_fin != sssv_pkg::RC_CONT) begin
          given_d     = 1'b1;
          res_o.valid = 1'b1;
          res_o.item.verdict = (code_fin == sssv_pkg::RC_BAD);
          res_o.item.stream_length = (code_fin == sssv_pkg::RC_END) ?
                                     sssv_pkg::LenW'(count_inc) : '0;
        end
      end
      // restart for the next stream
      if (item_i.last_byte) begin
        phase_d = sssv_pkg::PH_EVENT;
        run_d   = sssv_pkg::RS_NONE;
        left_d  = 3'd0;
        dseen_d = 3'd0;
        count_d = '0;
        given_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sssv_pkg::PH_EVENT;
      run_q   <= sssv_pkg::RS_NONE;
      left_q  <= 3'd0;
      dseen_q <= 3'd0;
      count_q <= '0;
      given_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      run_q   <= run_d;
      left_q  <= left_d;
      dseen_q <= dseen_d;
      count_q <= count_d;
      given_q <= given_d;
    end
  end

endmodule
